FILE: design/gpk_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpk_pkg
// Shared constants and types for the sprite to character LCD glyph packer.
// ---------------------------------------------------------------------------
package gpk_pkg;

  // LCD geometry and controller
  localparam int LCD_ROWS    = 2;
  localparam int LCD_COLS    = 16;
  localparam int GLYPH_SLOTS = 8;

  // sprite and cell geometry
  localparam int SPR_ROWS     = 7;
  localparam int SPR_COLS     = 11;
  localparam int CELL_PITCH_R = 9;
  localparam int CELL_PITCH_C = 6;
  localparam int GLYPH_W      = 5;
  localparam int GLYPH_H      = 8;
  localparam int CANVAS_ROWS  = LCD_ROWS * CELL_PITCH_R - 1;
  localparam int CANVAS_COLS  = LCD_COLS * CELL_PITCH_C - 1;
  localparam int NUM_CELLS    = LCD_ROWS * LCD_COLS;

  // derived widths
  localparam int OFS_W    = 8;
  localparam int COORD_W  = 9;   // holds any canvas coordinate or offset
  localparam int LR_W     = (LCD_ROWS > 1) ? $clog2(LCD_ROWS) : 1;
  localparam int LC_W     = (LCD_COLS > 1) ? $clog2(LCD_COLS) : 1;
  localparam int CNT_W    = $clog2(NUM_CELLS + 1);
  localparam int GLYPH_BITS = GLYPH_W * GLYPH_H;
  localparam int SROW_W   = $clog2(SPR_ROWS);
  localparam int SCOL_W   = $clog2(SPR_COLS);

  // configuration port
  localparam int PADDR_W = $clog2(SPR_ROWS * 4);
  localparam int PDATA_W = 32;

  typedef logic [SPR_ROWS-1:0][SPR_COLS-1:0] sprite_t;

  localparam sprite_t SPRITE_RESET = {
    11'd112, 11'd396, 11'd546, 11'd1137, 11'd546, 11'd396, 11'd112
  };

  // one queued frame tick
  typedef struct packed {
    logic [OFS_W-1:0] row_offset;
    logic [OFS_W-1:0] col_offset;
  } frame_t;

  // queue head as seen by the cell sequencer
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } q_head_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

endpackage

FILE: design/gpk_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpk_regs
// APB register file holding the seven sprite pixel rows.
// ---------------------------------------------------------------------------
module gpk_regs import gpk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output sprite_t            sprite
);

  logic [PADDR_W-3:0] reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite <= SPRITE_RESET;
    end else if (wr_en && (reg_idx < (PADDR_W-2)'(SPR_ROWS))) begin
      sprite[reg_idx] <= pwdata[SPR_COLS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx < (PADDR_W-2)'(SPR_ROWS)) begin
      prdata = PDATA_W'(sprite[reg_idx]);
    end
  end

endmodule

FILE: design/gpk_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpk_front
// Input side: takes frame ticks and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module gpk_front import gpk_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OFS_W-1:0] row_offset,
  input  logic [OFS_W-1:0] col_offset,
  output q_head_t          head,
  input  logic             pop
);

  frame_t     entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head.valid = (count != 2'd0);
  assign head.frame = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= '{row_offset: row_offset, col_offset: col_offset};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/gpk_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpk_back
// Cell sequencer: walks the LCD cells of one frame, builds each glyph from
// the sprite and offsets, numbers the custom-character slots.
// ---------------------------------------------------------------------------
module gpk_back import gpk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  sprite_t               sprite,
  input  q_head_t               head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  cell_row,
  output logic [3:0]            cell_col,
  output logic                  has_pixels,
  output logic [GLYPH_BITS-1:0] glyph,
  output logic [4:0]            slot,
  output logic                  slot_over_limit,
  output logic                  last_cell
);

  seq_state_t         state;
  seq_state_t         state_next;
  logic               running;
  logic [OFS_W-1:0]   ro;
  logic [OFS_W-1:0]   co;
  logic [LR_W-1:0]    lr;
  logic [LC_W-1:0]    lc;
  logic [COORD_W-1:0] base_r;
  logic [COORD_W-1:0] base_c;
  logic [CNT_W-1:0]   cnt;
  logic               adv;
  logic               last;
  logic               col_wrap;

  // glyph build
  logic [COORD_W-1:0]  r_abs  [GLYPH_H];
  logic [COORD_W-1:0]  dr     [GLYPH_H];
  logic [GLYPH_H-1:0]  row_hit;
  logic [SPR_COLS-1:0] row_bits [GLYPH_H];
  logic [COORD_W-1:0]  c_abs  [GLYPH_W];
  logic [COORD_W-1:0]  dc     [GLYPH_W];
  logic [GLYPH_W-1:0]  col_hit;
  logic [SCOL_W-1:0]   bit_pos [GLYPH_W];
  logic [GLYPH_BITS-1:0] glyph_c;
  logic                lit;

  // ---- state machine ----
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (head.valid) state_next = ST_RUN;
      ST_RUN:  if (adv && last && !head.valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    running = 1'b0;
    unique case (state)
      ST_IDLE: running = 1'b0;
      ST_RUN:  running = 1'b1;
      default: running = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign col_wrap = (lc == LC_W'(LCD_COLS - 1));
  assign last     = col_wrap && (lr == LR_W'(LCD_ROWS - 1));
  assign adv      = running && (!out_valid || !out_stall);
  // next frame starts right behind the last cell of the current one
  assign pop      = head.valid && (!running || (adv && last));

  // ---- glyph of the current cell ----
  always_comb begin
    for (int j = 0; j < GLYPH_H; j++) begin
      r_abs[j]    = base_r + COORD_W'(j);
      dr[j]       = r_abs[j] - COORD_W'(ro);
      row_hit[j]  = (r_abs[j] >= COORD_W'(ro)) && (dr[j] < COORD_W'(SPR_ROWS)) &&
                    (r_abs[j] < COORD_W'(CANVAS_ROWS));
      row_bits[j] = '0;
      if (row_hit[j]) row_bits[j] = sprite[dr[j][SROW_W-1:0]];
    end
    for (int i = 0; i < GLYPH_W; i++) begin
      c_abs[i]   = base_c + COORD_W'(i);
      dc[i]      = c_abs[i] - COORD_W'(co);
      col_hit[i] = (c_abs[i] >= COORD_W'(co)) && (dc[i] < COORD_W'(SPR_COLS)) &&
                   (c_abs[i] < COORD_W'(CANVAS_COLS));
      bit_pos[i] = SCOL_W'(SPR_COLS - 1) - dc[i][SCOL_W-1:0];
    end
    glyph_c = '0;
    for (int j = 0; j < GLYPH_H; j++) begin
      for (int i = 0; i < GLYPH_W; i++) begin
        glyph_c[GLYPH_W*j + GLYPH_W - 1 - i] = col_hit[i] && row_bits[j][bit_pos[i]];
      end
    end
    lit = |glyph_c;
  end

  // ---- cell walk ----
  // a new frame restarts the walk, even on the last cell of the previous one
  always_ff @(posedge clk) begin
    if (pop) begin
      ro     <= head.frame.row_offset;
      co     <= head.frame.col_offset;
      lr     <= '0;
      lc     <= '0;
      base_r <= '0;
      base_c <= '0;
      cnt    <= '0;
    end else if (adv) begin
      cnt <= cnt + CNT_W'(lit);
      if (col_wrap) begin
        lc     <= '0;
        base_c <= '0;
        lr     <= lr + LR_W'(1);
        base_r <= base_r + COORD_W'(CELL_PITCH_R);
      end else begin
        lc     <= lc + LC_W'(1);
        base_c <= base_c + COORD_W'(CELL_PITCH_C);
      end
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_row        <= 1'(lr);
      cell_col        <= 4'(lc);
      has_pixels      <= lit;
      glyph           <= glyph_c;
      slot            <= lit ? 5'(cnt) : 5'd0;
      slot_over_limit <= lit && (cnt >= CNT_W'(GLYPH_SLOTS));
      last_cell       <= last;
    end
  end

`ifndef SYNTHESIS
  a_pop_only_at_frame_end: assert property (@(posedge clk) disable iff (rst)
    (pop && running) |-> (adv && last))
    else $error("queue popped in the middle of a frame");

  a_empty_cell_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_pixels) |-> (glyph == '0 && slot == 5'd0 && !slot_over_limit))
    else $error("empty cell carries glyph or slot data");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (adv && last && !head.valid) |=> (state == ST_IDLE))
    else $error("sequencer kept running after the last cell");

  a_first_cell_after_pop: assert property (@(posedge clk) disable iff (rst)
    pop |=> (running && lr == '0 && lc == '0 && cnt == '0))
    else $error("cell walk not restarted on a new frame");
`endif

endmodule

FILE: design/sprite_to_char_lcd_glyph_packer_unit.sv
`timescale 1ns / 1ps
// A frame tick is held in the queue, then loaded into the cell sequencer;
// each cell result leaves through the output register. A frame has 32 cell
// results, one per cycle while out_stall is low.
// A two-entry frame queue takes new ticks while a frame is being emitted.
// Reset (rst, synchronous) restores the default sprite rows, empties the queue
// and idles the sequencer; no clearing pass is needed.
// ---------------------------------------------------------------------------
// sprite_to_char_lcd_glyph_packer_unit
// Places a configured 7x11 sprite on the LCD canvas and emits one 5x8 glyph
// per character cell, with custom-character slot numbering.
// ---------------------------------------------------------------------------
module sprite_to_char_lcd_glyph_packer_unit import gpk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready,
  // frame ticks
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OFS_W-1:0]      row_offset,
  input  logic [OFS_W-1:0]      col_offset,
  // cell results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  cell_row,
  output logic [3:0]            cell_col,
  output logic                  has_pixels,
  output logic [GLYPH_BITS-1:0] glyph,
  output logic [4:0]            slot,
  output logic                  slot_over_limit,
  output logic                  last_cell
);

  sprite_t sprite;
  q_head_t head;
  logic    pop;

  gpk_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sprite  (sprite)
  );

  gpk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .row_offset (row_offset),
    .col_offset (col_offset),
    .head       (head),
    .pop        (pop)
  );

  gpk_back u_back (
    .clk             (clk),
    .rst             (rst),
    .sprite          (sprite),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cell_row        (cell_row),
    .cell_col        (cell_col),
    .has_pixels      (has_pixels),
    .glyph           (glyph),
    .slot            (slot),
    .slot_over_limit (slot_over_limit),
    .last_cell       (last_cell)
  );

endmodule

FILE: tb/glyph_frame_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// glyph_frame_checker
// Watches the register port and both channels of the glyph packer. On every
// accepted frame tick it renders the sprite onto the LCD canvas and queues
// the 32 expected cells. It compares each cell transfer with the oldest one.
// ---------------------------------------------------------------------------
module glyph_frame_checker import gpk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [OFS_W-1:0]      row_offset,
  input  logic [OFS_W-1:0]      col_offset,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  cell_row,
  input  logic [3:0]            cell_col,
  input  logic                  has_pixels,
  input  logic [GLYPH_BITS-1:0] glyph,
  input  logic [4:0]            slot,
  input  logic                  slot_over_limit,
  input  logic                  last_cell,
  output int                    fail_count,
  output int                    pending
);

  localparam int N_LCD_ROWS = 2;
  localparam int N_LCD_COLS = 16;
  localparam int N_SLOTS    = 8;
  localparam int PITCH_R    = 9;
  localparam int PITCH_C    = 6;
  localparam int CELL_W     = 5;
  localparam int CELL_H     = 8;
  localparam int SP_ROWS    = 7;
  localparam int SP_COLS    = 11;
  localparam int CNV_ROWS   = N_LCD_ROWS * PITCH_R - 1;
  localparam int CNV_COLS   = N_LCD_COLS * PITCH_C - 1;

  typedef struct packed {
    logic        row;
    logic [3:0]  col;
    logic        lit;
    logic [39:0] bits;
    logic [4:0]  slot;
    logic        over;
    logic        last;
  } lcd_cell_t;

  logic [SP_COLS-1:0] sprite_rows [SP_ROWS];
  lcd_cell_t          cells_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Render the sprite at (ro, co) and queue one expected cell per LCD cell.
  function automatic void place_sprite_frame(input logic [7:0] ro, input logic [7:0] co);
    int lr, lc, j, i, r, c, dr, dc, used;
    lcd_cell_t e;
    used = 0;
    for (lr = 0; lr < N_LCD_ROWS; lr++) begin
      for (lc = 0; lc < N_LCD_COLS; lc++) begin
        e = '0;
        for (j = 0; j < CELL_H; j++) begin
          for (i = 0; i < CELL_W; i++) begin
            r = lr * PITCH_R + j;
            c = lc * PITCH_C + i;
            if (r < CNV_ROWS && c < CNV_COLS && r >= int'(ro) && c >= int'(co)) begin
              dr = r - int'(ro);
              dc = c - int'(co);
              if (dr < SP_ROWS && dc < SP_COLS && sprite_rows[dr][SP_COLS-1-dc])
                e.bits[CELL_W*j + CELL_W-1-i] = 1'b1;
            end
          end
        end
        e.row = lr[0];
        e.col = lc[3:0];
        e.lit = |e.bits;
        if (e.lit) begin
          e.slot = used[4:0];
          e.over = (used >= N_SLOTS);
          used++;
        end
        e.last = (lr * N_LCD_COLS + lc == N_LCD_ROWS * N_LCD_COLS - 1);
        cells_due.push_back(e);
      end
    end
  endfunction

  task automatic check_field(input string name, input lcd_cell_t e,
                             input logic [63:0] want, input logic [63:0] got);
    if (want !== got)
      flag_mismatch($sformatf("cell (%0d,%0d) %s: expected %0h, got %0h",
                              e.row, e.col, name, want, got));
  endtask

  always @(posedge clk) begin
    lcd_cell_t e;
    if (rst) begin
      sprite_rows[0] = 11'd112;
      sprite_rows[1] = 11'd396;
      sprite_rows[2] = 11'd546;
      sprite_rows[3] = 11'd1137;
      sprite_rows[4] = 11'd546;
      sprite_rows[5] = 11'd396;
      sprite_rows[6] = 11'd112;
      cells_due.delete();
    end else begin
      // register write; indexes past the sprite rows are ignored
      if (psel && penable && pwrite && pready && int'(paddr[PADDR_W-1:2]) < SP_ROWS)
        sprite_rows[paddr[PADDR_W-1:2]] = pwdata[SP_COLS-1:0];

      if (out_valid && !out_stall) begin
        if (cells_due.size() == 0) begin
          flag_mismatch($sformatf("cell transfer (%0d,%0d) with nothing expected",
                                  cell_row, cell_col));
        end else begin
          e = cells_due.pop_front();
          check_field("cell_row", e, e.row, cell_row);
          check_field("cell_col", e, e.col, cell_col);
          check_field("has_pixels", e, e.lit, has_pixels);
          check_field("glyph", e, e.bits, glyph);
          check_field("slot", e, e.slot, slot);
          check_field("slot_over_limit", e, e.over, slot_over_limit);
          check_field("last_cell", e, e.last, last_cell);
        end
      end

      if (in_valid && !in_stall)
        place_sprite_frame(row_offset, col_offset);
    end
    pending = cells_due.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench for the glyph packer: directed frame ticks at the canvas edges,
// then random ticks under several sprite patterns and idle/stall mixes.
// ---------------------------------------------------------------------------
module tb;
  import gpk_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum int {PAT_ONES, PAT_ZERO, PAT_RANDOM, PAT_STRIPES} sprite_pat_t;

  localparam int NUM_SPRITE_REGS = 7;   // index 7 is past the last register
  localparam int REG_STRIDE      = 4;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 16;
  localparam int NUM_PHASES      = 7;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [PDATA_W-1:0]    pwdata;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_stall;
  logic [OFS_W-1:0]      row_offset;
  logic [OFS_W-1:0]      col_offset;
  logic                  out_valid;
  logic                  out_stall;
  logic                  cell_row;
  logic [3:0]            cell_col;
  logic                  has_pixels;
  logic [GLYPH_BITS-1:0] glyph;
  logic [4:0]            slot;
  logic                  slot_over_limit;
  logic                  last_cell;

  int fail_count;
  int pending;
  int cycles;
  int send_gap_pct;
  int stall_pct;

  sprite_to_char_lcd_glyph_packer_unit DUT (.*);

  glyph_frame_checker chk (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  task automatic set_idle(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin send_gap_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin send_gap_pct = 85; stall_pct = 0;  end
      IDLE_RECV: begin send_gap_pct = 0;  stall_pct = 85; end
      default:   begin send_gap_pct = 9;  stall_pct = 9;  end
    endcase
  endtask

  task automatic write_reg(input int idx, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PADDR_W'(idx * REG_STRIDE);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // upper data bits carry junk so the 11-bit masking gets exercised
  task automatic load_sprite(input sprite_pat_t pat);
    logic [PDATA_W-1:0] v;
    for (int i = 0; i < NUM_SPRITE_REGS; i++) begin
      v = $urandom;
      case (pat)
        PAT_ONES:    v[10:0] = 11'h7FF;
        PAT_ZERO:    v[10:0] = 11'h000;
        PAT_STRIPES: v[10:0] = i[0] ? 11'h2AA : 11'h555;
        default:     ;
      endcase
      write_reg(i, v);
    end
  endtask

  task automatic send_frame(input logic [7:0] ro, input logic [7:0] co);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    row_offset <= ro;
    col_offset <= co;
    do @(posedge clk); while (in_stall);
  endtask

  // mostly offsets that land the sprite on or near the canvas
  task automatic send_random_frame();
    if ($urandom_range(99) < 85)
      send_frame(8'($urandom_range(18)), 8'($urandom_range(98)));
    else
      send_frame(8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int counts [NUM_PHASES];
    sprite_pat_t pats [NUM_PHASES];
    counts = '{40, 30, 60, 80, 60, 40, 34};
    pats   = '{PAT_ONES, PAT_ZERO, PAT_RANDOM, PAT_RANDOM, PAT_STRIPES,
               PAT_RANDOM, PAT_RANDOM};
    cycles     = 0;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    row_offset = '0;
    col_offset = '0;
    out_stall  = 1'b0;
    set_idle(IDLE_NONE);
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // default sprite: corners, offset extremes, canvas edges, cell seams
    send_frame(8'd0, 8'd0);
    send_frame(8'd255, 8'd255);
    send_frame(8'd0, 8'd255);
    send_frame(8'd255, 8'd0);
    send_frame(8'd17, 8'd95);
    send_frame(8'd16, 8'd94);
    send_frame(8'd10, 8'd0);
    send_frame(8'd1, 8'd1);
    send_frame(8'd5, 8'd3);
    send_frame(8'd6, 8'd88);
    send_frame(8'd9, 8'd40);
    send_frame(8'd3, 8'd85);
    send_frame(8'd12, 8'd10);
    send_frame(8'd170, 8'd85);
    send_frame(8'd85, 8'd170);
    send_frame(8'd8, 8'd5);
    send_frame(8'd0, 8'd90);
    send_frame(8'd13, 8'd60);
    send_frame(8'd2, 8'd20);
    send_frame(8'd16, 8'd0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      load_sprite(pats[p]);
      if (p == 0)
        write_reg(NUM_SPRITE_REGS, $urandom);   // out of range, must be ignored
      set_idle(idle_mode_t'(p % 4));
      for (int n = 0; n < counts[p]; n++)
        send_random_frame();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
design/gpk_pkg.sv
design/gpk_regs.sv
design/gpk_front.sv
design/gpk_back.sv
design/sprite_to_char_lcd_glyph_packer_unit.sv
tb/glyph_frame_checker.sv
tb/tb.sv
